### design/dsb_pkg.sv
// shared types, constants and helpers for the domain suffix blocklist
`default_nettype none
package dsb_pkg;

    localparam int ENTRIES_DEF    = 32;
    localparam int NAME_BYTES_DEF = 64;

    localparam logic [1:0] CMD_LOOKUP = 2'd0;
    localparam logic [1:0] CMD_ADD    = 2'd1;
    localparam logic [1:0] CMD_REMOVE = 2'd2;

    localparam logic [7:0] CH_DOT  = 8'h2e;
    localparam logic [7:0] CH_UP_A = 8'h41;
    localparam logic [7:0] CH_UP_Z = 8'h5a;
    localparam logic [7:0] CASE_OFS = 8'h20;

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] character;
        logic       last_char;
    } t_in;

    typedef struct packed {
        logic       outcome;
        logic [5:0] entry_total;
    } t_out;

    function automatic logic [7:0] fold(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= CH_UP_A && c <= CH_UP_Z) begin
            r = c + CASE_OFS;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

### design/dsb_ram.sv
// generic single write port ram with registered read
`default_nettype none
module dsb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

### design/dsb_front.sv
// front end: collects name bytes into the name buffers and queues one command
`default_nettype none
module dsb_front #(
    parameter int NAME_BYTES = dsb_pkg::NAME_BYTES_DEF,
    localparam int NW = $clog2(NAME_BYTES + 1),
    localparam int PW = $clog2(NAME_BYTES)
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    input  wire dsb_pkg::t_in    i_in_data,
    output logic                 o_in_ready,
    output logic                 o_head_we,
    output logic [PW-1:0]        o_head_waddr,
    output logic                 o_tail_we,
    output logic [PW-1:0]        o_tail_waddr,
    output logic [7:0]           o_name_wdata,
    output logic                 o_job_valid,
    output logic [1:0]           o_job_cmd,
    output logic [NW-1:0]        o_job_nl,
    output logic [PW-1:0]        o_job_wptr,
    input  wire logic            i_job_pop,
    input  wire logic            i_back_busy
);

    localparam logic [NW-1:0] HEAD_MAX = NW'(NAME_BYTES - 1);
    localparam logic [NW-1:0] LEN_MAX  = NW'(NAME_BYTES);
    localparam logic [PW-1:0] PTR_LAST = PW'(NAME_BYTES - 1);

    logic [NW-1:0] r_len;
    logic [PW-1:0] r_wptr;
    logic          r_job_valid;
    logic [1:0]    r_job_cmd;
    logic [NW-1:0] r_job_nl;
    logic [PW-1:0] r_job_wptr;

    logic          xfer;
    logic          has_ch;
    logic [NW-1:0] len_nx;
    logic [PW-1:0] wptr_nx;

    assign o_in_ready   = !r_job_valid && !i_back_busy;
    assign xfer         = i_in_valid && o_in_ready;
    assign has_ch       = i_in_data.character != 8'd0;
    assign len_nx       = (has_ch && r_len < LEN_MAX) ? r_len + NW'(1) : r_len;
    assign wptr_nx      = !has_ch ? r_wptr : ((r_wptr == PTR_LAST) ? '0 : r_wptr + PW'(1));

    assign o_head_we    = xfer && has_ch && r_len < HEAD_MAX;
    assign o_head_waddr = PW'(r_len);
    assign o_tail_we    = xfer && has_ch;
    assign o_tail_waddr = r_wptr;
    assign o_name_wdata = i_in_data.character;

    assign o_job_valid  = r_job_valid;
    assign o_job_cmd    = r_job_cmd;
    assign o_job_nl     = r_job_nl;
    assign o_job_wptr   = r_job_wptr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len       <= '0;
            r_wptr      <= '0;
            r_job_valid <= 1'b0;
        end else begin
            if (i_job_pop) begin
                r_job_valid <= 1'b0;
            end
            if (xfer) begin
                r_wptr <= wptr_nx;
                if (i_in_data.last_char) begin
                    r_job_valid <= 1'b1;
                    r_job_cmd   <= i_in_data.command;
                    r_job_nl    <= len_nx;
                    r_job_wptr  <= wptr_nx;
                    r_len       <= '0;
                end else begin
                    r_len <= len_nx;
                end
            end
        end
    end

endmodule
`default_nettype wire

### design/dsb_back.sv
// back end: table sequencer for lookup, add and remove, with the result register
`default_nettype none
module dsb_back #(
    parameter int ENTRIES    = dsb_pkg::ENTRIES_DEF,
    parameter int NAME_BYTES = dsb_pkg::NAME_BYTES_DEF,
    localparam int NW = $clog2(NAME_BYTES + 1),
    localparam int PW = $clog2(NAME_BYTES)
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_job_valid,
    input  wire logic [1:0]    i_job_cmd,
    input  wire logic [NW-1:0] i_job_nl,
    input  wire logic [PW-1:0] i_job_wptr,
    output logic               o_job_pop,
    output logic               o_busy,
    output logic [PW-1:0]      o_head_raddr,
    input  wire logic [7:0]    i_head_rdata,
    output logic [PW-1:0]      o_tail_raddr,
    input  wire logic [7:0]    i_tail_rdata,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output dsb_pkg::t_out      o_out_data
);

    localparam int EW  = $clog2((ENTRIES > 1) ? ENTRIES : 2);
    localparam int CW  = $clog2(ENTRIES + 1);
    localparam int AW  = EW + PW;
    localparam int XW  = 9;
    localparam logic [PW-1:0] LEN_SLOT = PW'(NAME_BYTES - 1);
    localparam logic [XW-1:0] HEAD_MAX = XW'(NAME_BYTES - 1);
    localparam logic [CW-1:0] FULL     = CW'(ENTRIES);

    typedef enum logic [3:0] {
        S_IDLE, S_ENT, S_LEN, S_DOT, S_RD, S_CMP,
        S_SH, S_SHRD, S_SHWR, S_CPRD, S_CPWR, S_DONE
    } t_state;

    t_state        r_state, n_state;
    logic [1:0]    r_cmd, n_cmd;
    logic [NW-1:0] r_nl, n_nl;
    logic [PW-1:0] r_wptr, n_wptr;
    logic [CW-1:0] r_e, n_e;
    logic [PW-1:0] r_i, n_i;
    logic [7:0]    r_bl, n_bl;
    logic [CW-1:0] r_total, n_total;
    logic          r_ok, n_ok;
    logic          r_out_valid, n_out_valid;
    dsb_pkg::t_out r_out_data, n_out_data;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [7:0]    ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [7:0]    ram_rdata;

    logic [PW:0]   k;
    logic [PW+1:0] tsum;
    logic [XW-1:0] nl_x, bl_x, rbl_x, i1_x;
    logic [PW-1:0] copy_n;
    logic          eq;
    logic          match;

    dsb_ram #(.WIDTH(8), .DEPTH(1 << AW)) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign nl_x   = XW'(r_nl);
    assign bl_x   = XW'(ram_rdata);
    assign rbl_x  = XW'(r_bl);
    assign i1_x   = XW'(r_i) + XW'(1);
    assign copy_n = (nl_x > HEAD_MAX) ? LEN_SLOT : PW'(r_nl);
    assign eq     = (r_cmd == dsb_pkg::CMD_LOOKUP)
                    ? (dsb_pkg::fold(ram_rdata) == dsb_pkg::fold(i_tail_rdata))
                    : (ram_rdata == i_head_rdata);

    // byte k places from the end of the name
    always_comb begin
        if (r_state == S_LEN) begin
            k = (PW+1)'(ram_rdata) + (PW+1)'(1);
        end else begin
            k = (PW+1)'(r_bl) - (PW+1)'(r_i);
        end
        tsum = (PW+2)'(r_wptr) + (PW+2)'(NAME_BYTES) - (PW+2)'(k);
        if (tsum >= (PW+2)'(NAME_BYTES)) begin
            tsum = tsum - (PW+2)'(NAME_BYTES);
        end
        o_tail_raddr = PW'(tsum);
    end

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_nl        = r_nl;
        n_wptr      = r_wptr;
        n_e         = r_e;
        n_i         = r_i;
        n_bl        = r_bl;
        n_total     = r_total;
        n_ok        = r_ok;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_data  = r_out_data;
        ram_we      = 1'b0;
        ram_waddr   = {r_e[EW-1:0], r_i};
        ram_wdata   = ram_rdata;
        ram_raddr   = {r_e[EW-1:0], r_i};
        o_head_raddr = r_i;
        o_job_pop   = 1'b0;
        match       = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_job_valid) begin
                    o_job_pop = 1'b1;
                    n_cmd     = i_job_cmd;
                    n_nl      = i_job_nl;
                    n_wptr    = i_job_wptr;
                    n_e       = '0;
                    n_i       = '0;
                    n_ok      = 1'b0;
                    unique case (i_job_cmd)
                        dsb_pkg::CMD_LOOKUP: n_state = S_ENT;
                        dsb_pkg::CMD_ADD: begin
                            if (r_total >= FULL) begin
                                n_state = S_DONE;
                            end else if (XW'(i_job_nl) > HEAD_MAX) begin
                                n_state = S_CPRD;
                            end else begin
                                n_state = S_ENT;
                            end
                        end
                        dsb_pkg::CMD_REMOVE: begin
                            if (XW'(i_job_nl) > HEAD_MAX) begin
                                n_state = S_DONE;
                            end else begin
                                n_state = S_ENT;
                            end
                        end
                        default: n_state = S_DONE;
                    endcase
                end
            end
            S_ENT: begin
                ram_raddr = {r_e[EW-1:0], LEN_SLOT};
                if (r_e == r_total) begin
                    n_i     = '0;
                    n_state = (r_cmd == dsb_pkg::CMD_ADD) ? S_CPRD : S_DONE;
                end else begin
                    n_state = S_LEN;
                end
            end
            S_LEN: begin
                n_bl = ram_rdata;
                n_i  = '0;
                if (r_cmd == dsb_pkg::CMD_LOOKUP) begin
                    if (bl_x == '0 || nl_x < bl_x) begin
                        n_e     = r_e + CW'(1);
                        n_state = S_ENT;
                    end else if (nl_x == bl_x) begin
                        n_state = S_RD;
                    end else begin
                        n_state = S_DOT;
                    end
                end else begin
                    if (nl_x != bl_x) begin
                        n_e     = r_e + CW'(1);
                        n_state = S_ENT;
                    end else if (bl_x == '0) begin
                        match = 1'b1;
                    end else begin
                        n_state = S_RD;
                    end
                end
            end
            S_DOT: begin
                if (i_tail_rdata == dsb_pkg::CH_DOT) begin
                    n_state = S_RD;
                end else begin
                    n_e     = r_e + CW'(1);
                    n_state = S_ENT;
                end
            end
            S_RD: begin
                n_state = S_CMP;
            end
            S_CMP: begin
                if (!eq) begin
                    n_e     = r_e + CW'(1);
                    n_state = S_ENT;
                end else if (i1_x == rbl_x) begin
                    match = 1'b1;
                end else begin
                    n_i     = r_i + PW'(1);
                    n_state = S_RD;
                end
            end
            S_SH: begin
                n_i = '0;
                if ((CW+1)'(r_e) + (CW+1)'(1) >= (CW+1)'(r_total)) begin
                    n_total = r_total - CW'(1);
                    n_ok    = 1'b1;
                    n_state = S_DONE;
                end else begin
                    n_state = S_SHRD;
                end
            end
            S_SHRD: begin
                ram_raddr = {EW'(r_e + CW'(1)), r_i};
                n_state   = S_SHWR;
            end
            S_SHWR: begin
                ram_we = 1'b1;
                if (r_i == LEN_SLOT) begin
                    n_e     = r_e + CW'(1);
                    n_state = S_SH;
                end else begin
                    n_i     = r_i + PW'(1);
                    n_state = S_SHRD;
                end
            end
            S_CPRD: begin
                if (r_i == copy_n) begin
                    ram_we    = 1'b1;
                    ram_waddr = {r_total[EW-1:0], LEN_SLOT};
                    ram_wdata = 8'(copy_n);
                    n_total   = r_total + CW'(1);
                    n_ok      = 1'b1;
                    n_state   = S_DONE;
                end else begin
                    n_state = S_CPWR;
                end
            end
            S_CPWR: begin
                ram_we    = 1'b1;
                ram_waddr = {r_total[EW-1:0], r_i};
                ram_wdata = i_head_rdata;
                n_i       = r_i + PW'(1);
                n_state   = S_CPRD;
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid            = 1'b1;
                    n_out_data.outcome     = r_ok;
                    n_out_data.entry_total = 6'(r_total);
                    n_state                = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        if (match) begin
            unique case (r_cmd)
                dsb_pkg::CMD_LOOKUP: begin
                    n_ok    = 1'b1;
                    n_state = S_DONE;
                end
                dsb_pkg::CMD_REMOVE: n_state = S_SH;
                default: begin
                    n_ok    = 1'b0;
                    n_state = S_DONE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_total     <= n_total;
            r_out_valid <= n_out_valid;
        end
        r_cmd      <= n_cmd;
        r_nl       <= n_nl;
        r_wptr     <= n_wptr;
        r_e        <= n_e;
        r_i        <= n_i;
        r_bl       <= n_bl;
        r_ok       <= n_ok;
        r_out_data <= n_out_data;
    end

    assign o_busy      = r_state != S_IDLE && r_state != S_DONE;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule
`default_nettype wire

### design/domain_suffix_blocklist.sv
// top level of the domain suffix blocklist
//
//  channel  direction  handshake                  payload
//  in       in         i_in_valid / o_in_ready    i_in_data  (command, character, last_char)
//  out      out        o_out_valid / i_out_ready  o_out_data (outcome, entry_total)
//
// the front buffers a byte that does not end a name in the name rams
// a command then runs in the back sequencer over the entry ram: lookup and the
// add/remove search read each entry's length (lookup with a dot check) and compare
// its bytes, add then copies the name's bytes and writes its length, remove moves each
// later entry down; new bytes are held off until the command ends
// synchronous active-low reset empties the table; no clearing pass is needed
// a waiting result does not hold the next name's bytes
`default_nettype none
module domain_suffix_blocklist #(
    parameter int ENTRIES    = dsb_pkg::ENTRIES_DEF,
    parameter int NAME_BYTES = dsb_pkg::NAME_BYTES_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire dsb_pkg::t_in  i_in_data,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output dsb_pkg::t_out      o_out_data
);

    localparam int NW = $clog2(NAME_BYTES + 1);
    localparam int PW = $clog2(NAME_BYTES);

    logic          head_we, tail_we;
    logic [PW-1:0] head_waddr, tail_waddr, head_raddr, tail_raddr;
    logic [7:0]    name_wdata, head_rdata, tail_rdata;
    logic          job_valid, job_pop, back_busy;
    logic [1:0]    job_cmd;
    logic [NW-1:0] job_nl;
    logic [PW-1:0] job_wptr;

    dsb_front #(.NAME_BYTES(NAME_BYTES)) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_data    (i_in_data),
        .o_in_ready   (o_in_ready),
        .o_head_we    (head_we),
        .o_head_waddr (head_waddr),
        .o_tail_we    (tail_we),
        .o_tail_waddr (tail_waddr),
        .o_name_wdata (name_wdata),
        .o_job_valid  (job_valid),
        .o_job_cmd    (job_cmd),
        .o_job_nl     (job_nl),
        .o_job_wptr   (job_wptr),
        .i_job_pop    (job_pop),
        .i_back_busy  (back_busy)
    );

    dsb_ram #(.WIDTH(8), .DEPTH(1 << PW)) u_head_ram (
        .i_clk   (i_clk),
        .i_we    (head_we),
        .i_waddr (head_waddr),
        .i_wdata (name_wdata),
        .i_raddr (head_raddr),
        .o_rdata (head_rdata)
    );

    dsb_ram #(.WIDTH(8), .DEPTH(1 << PW)) u_tail_ram (
        .i_clk   (i_clk),
        .i_we    (tail_we),
        .i_waddr (tail_waddr),
        .i_wdata (name_wdata),
        .i_raddr (tail_raddr),
        .o_rdata (tail_rdata)
    );

    dsb_back #(.ENTRIES(ENTRIES), .NAME_BYTES(NAME_BYTES)) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_job_valid  (job_valid),
        .i_job_cmd    (job_cmd),
        .i_job_nl     (job_nl),
        .i_job_wptr   (job_wptr),
        .o_job_pop    (job_pop),
        .o_busy       (back_busy),
        .o_head_raddr (head_raddr),
        .i_head_rdata (head_rdata),
        .o_tail_raddr (tail_raddr),
        .i_tail_rdata (tail_rdata),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_data   (o_out_data)
    );

endmodule
`default_nettype wire
